// File: rtl/mhpq_pkg.sv
// Shared constants and types for the max-heap priority queue.
package mhpq_pkg;

   localparam int DATA_W        = 32;
   localparam int CAP_W         = 11;
   localparam int DEPTH_DEFAULT = 1024;
   localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(1024);

   localparam logic OP_INSERT  = 1'b0;
   localparam logic OP_EXTRACT = 1'b1;

   typedef enum logic [1:0] {
      STATUS_OK        = 2'd0,
      STATUS_OVERFLOW  = 2'd1,
      STATUS_UNDERFLOW = 2'd2
   } status_type;

endpackage

// File: rtl/max_heap_priority_queue.sv
// Binary max-heap priority queue with a sequenced sift unit over one store.
//
//   channel  direction  handshake                 contents
//   req      in         req_tvalid / req_tready   tuser: op, tdata: value
//   rsp      out        rsp_tvalid / rsp_tready   tuser: status, tdata: result_value
//   csr      in         csr_we                    capacity_limit
//
// An insert climbs a level per pass through its check and compare states; an extract reads
// the root and the last item, then descends a level per pass through its check, left,
// right (if a right child exists) and decide states. Overflow and underflow go to ST_RESP.
// The single-port store with its registered read and the one comparator set this order.
// Reset empties the heap at once and sets the capacity to 1024; the store is not cleared.
// A new item is accepted while a result waits on rsp; a stalled rsp holds the final state.
module max_heap_priority_queue
   import mhpq_pkg::*;
#(
   parameter int DEPTH = DEPTH_DEFAULT
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_tvalid,
   output logic              req_tready,
   input  logic [DATA_W-1:0] req_tdata,   // [31:0] value
   input  logic              req_tuser,   // [0] op
   output logic              rsp_tvalid,
   input  logic              rsp_tready,
   output logic [DATA_W-1:0] rsp_tdata,   // [31:0] result_value
   output logic [1:0]        rsp_tuser,   // [1:0] status
   input  logic              csr_we,
   input  logic [CAP_W-1:0]  csr_wdata
);

   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int PW = $clog2(DEPTH + 1);
   localparam int CW = (PW > CAP_W) ? PW : CAP_W;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_INS_CHK,
      ST_INS_CMP,
      ST_EXT_LAST,
      ST_EXT_LOAD,
      ST_EXT_CHK,
      ST_EXT_LEFT,
      ST_EXT_RIGHT,
      ST_EXT_DEC,
      ST_RESP
   } state_type;

   state_type         state_ff, state_in;
   logic [CAP_W-1:0]  cap_ff, cap_in;
   logic [PW-1:0]     count_ff, count_in;
   logic [PW-1:0]     pos_ff, pos_in;
   logic [PW-1:0]     best_ff, best_in;
   logic [DATA_W-1:0] carry_ff, carry_in;
   logic [DATA_W-1:0] bval_ff, bval_in;
   logic [DATA_W-1:0] res_value_ff, res_value_in;
   status_type        res_status_ff, res_status_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [DATA_W-1:0] rsp_data_ff, rsp_data_in;
   logic [1:0]        rsp_user_ff, rsp_user_in;

   logic [DATA_W-1:0] mem [DEPTH];
   logic [DATA_W-1:0] rd_data_ff;
   logic [AW-1:0]     mem_raddr;
   logic [AW-1:0]     mem_waddr;
   logic [DATA_W-1:0] mem_wdata;
   logic              mem_we;

   logic signed [DATA_W-1:0] cmp_a, cmp_b;
   logic              cmp_gt;
   logic [PW:0]       left_pos, right_pos, count_wide;
   logic              heap_full;
   logic              accept;

   assign accept     = req_tvalid && req_tready;
   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;

   assign left_pos   = {pos_ff, 1'b0};
   assign right_pos  = left_pos + (PW+1)'(1);
   assign count_wide = {1'b0, count_ff};
   assign heap_full  = (CW'(count_ff) >= CW'(cap_ff)) || (CW'(count_ff) >= CW'(DEPTH));

   // The one signed comparator, shared by every sift step.
   assign cmp_gt = cmp_a > cmp_b;

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_waddr] <= mem_wdata;
      end
      rd_data_ff <= mem[mem_raddr];
   end

   always_comb begin
      state_in      = state_ff;
      cap_in        = csr_we ? csr_wdata : cap_ff;
      count_in      = count_ff;
      pos_in        = pos_ff;
      best_in       = best_ff;
      carry_in      = carry_ff;
      bval_in       = bval_ff;
      res_value_in  = res_value_ff;
      res_status_in = res_status_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_data_in   = rsp_data_ff;
      rsp_user_in   = rsp_user_ff;
      mem_raddr     = '0;
      mem_waddr     = AW'(pos_ff - PW'(1));
      mem_wdata     = carry_ff;
      mem_we        = 1'b0;
      cmp_a         = $signed(carry_ff);
      cmp_b         = $signed(rd_data_ff);

      unique case (state_ff)
         ST_IDLE: begin
            // The root is read here so it is ready if an extract arrives.
            mem_raddr = '0;
            if (accept) begin
               res_value_in  = '0;
               res_status_in = STATUS_OK;
               if (req_tuser == OP_INSERT) begin
                  if (heap_full) begin
                     res_status_in = STATUS_OVERFLOW;
                     state_in      = ST_RESP;
                  end else begin
                     count_in = count_ff + PW'(1);
                     pos_in   = count_ff + PW'(1);
                     carry_in = req_tdata;
                     state_in = ST_INS_CHK;
                  end
               end else begin
                  if (count_ff == '0) begin
                     res_status_in = STATUS_UNDERFLOW;
                     state_in      = ST_RESP;
                  end else begin
                     state_in = ST_EXT_LAST;
                  end
               end
            end
         end
         ST_INS_CHK: begin
            if (pos_ff == PW'(1)) begin
               mem_we   = 1'b1;
               state_in = ST_RESP;
            end else begin
               mem_raddr = AW'((pos_ff >> 1) - PW'(1));
               state_in  = ST_INS_CMP;
            end
         end
         ST_INS_CMP: begin
            cmp_a  = $signed(carry_ff);
            cmp_b  = $signed(rd_data_ff);
            mem_we = 1'b1;
            if (cmp_gt) begin
               // The parent moves down into the hole and the hole climbs.
               mem_wdata = rd_data_ff;
               pos_in    = pos_ff >> 1;
               state_in  = ST_INS_CHK;
            end else begin
               state_in = ST_RESP;
            end
         end
         ST_EXT_LAST: begin
            res_value_in = rd_data_ff;
            mem_raddr    = AW'(count_ff - PW'(1));
            count_in     = count_ff - PW'(1);
            state_in     = ST_EXT_LOAD;
         end
         ST_EXT_LOAD: begin
            carry_in = rd_data_ff;
            pos_in   = PW'(1);
            state_in = ST_EXT_CHK;
         end
         ST_EXT_CHK: begin
            if (left_pos > count_wide) begin
               mem_we   = 1'b1;
               state_in = ST_RESP;
            end else begin
               mem_raddr = AW'(left_pos - (PW+1)'(1));
               state_in  = ST_EXT_LEFT;
            end
         end
         ST_EXT_LEFT: begin
            cmp_a = $signed(rd_data_ff);
            cmp_b = $signed(carry_ff);
            if (cmp_gt) begin
               best_in = PW'(left_pos);
               bval_in = rd_data_ff;
            end else begin
               best_in = pos_ff;
               bval_in = carry_ff;
            end
            if (right_pos <= count_wide) begin
               mem_raddr = AW'(right_pos - (PW+1)'(1));
               state_in  = ST_EXT_RIGHT;
            end else begin
               state_in = ST_EXT_DEC;
            end
         end
         ST_EXT_RIGHT: begin
            // Strictly greater, so a tie keeps the earlier choice, the left child or the parent.
            cmp_a = $signed(rd_data_ff);
            cmp_b = $signed(bval_ff);
            if (cmp_gt) begin
               best_in = PW'(right_pos);
               bval_in = rd_data_ff;
            end
            state_in = ST_EXT_DEC;
         end
         ST_EXT_DEC: begin
            mem_we = 1'b1;
            if (best_ff == pos_ff) begin
               state_in = ST_RESP;
            end else begin
               mem_wdata = bval_ff;
               pos_in    = best_ff;
               state_in  = ST_EXT_CHK;
            end
         end
         ST_RESP: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = res_value_ff;
               rsp_user_in  = res_status_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         cap_ff        <= CAP_RESET;
         count_ff      <= '0;
         rsp_valid_ff  <= 1'b0;
         res_status_ff <= STATUS_OK;
      end else begin
         state_ff      <= state_in;
         cap_ff        <= cap_in;
         count_ff      <= count_in;
         rsp_valid_ff  <= rsp_valid_in;
         res_status_ff <= res_status_in;
      end
      pos_ff       <= pos_in;
      best_ff      <= best_in;
      carry_ff     <= carry_in;
      bval_ff      <= bval_in;
      res_value_ff <= res_value_in;
      rsp_data_ff  <= rsp_data_in;
      rsp_user_ff  <= rsp_user_in;
   end

endmodule
